@@ design/pbd_pkg.sv @@
// Shared types and constants for the ByteRun1 planar body decoder.
// No dependencies; imported by the decoder core, the output buffer and the top level.
`timescale 1ns / 1ps

package pbd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COMPRESSED = 3'd0;
    localparam logic [2:0] CFG_ROW_BYTES  = 3'd1;
    localparam logic [2:0] CFG_PLANES     = 3'd2;
    localparam logic [2:0] CFG_HAS_MASK   = 3'd3;
    localparam logic [2:0] CFG_ROWS       = 3'd4;
    localparam logic [2:0] CFG_PAD_ODD    = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Field widths.
    localparam int ROWB_W  = 13;
    localparam int PLANE_W = 4;
    localparam int ROWS_W  = 13;
    localparam int PROD_W  = ROWB_W + PLANE_W;      // row_bytes * planes
    localparam int TOTAL_W = PROD_W + ROWS_W;       // bytes in the whole image
    localparam int EMIT_W  = 28;                    // emitted-byte counter

    // Control byte that does nothing; below it is a literal run, above it a repeat.
    localparam logic [7:0] NOOP_CTRL = 8'h80;

    // Decoder phase. Compressed mode: control, literal bytes, repeat byte.
    // Raw mode reuses the codes: data, mask row, pad byte.
    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } t_phase;

    // Settings seen by the decoder core, already saturated.
    typedef struct packed {
        logic                 compressed;
        logic                 has_mask;
        logic                 pad_odd;
        logic [ROWB_W-1:0]    rb;
        logic [PLANE_W-1:0]   np;
        logic [TOTAL_W-1:0]   total;
    } t_cfg;

    // One decoded run.
    typedef struct packed {
        logic       body_done;
        logic [7:0] out_count;
        logic [7:0] out_byte;
    } t_result;

endpackage

@@ design/pbd_core.sv @@
// Decoder core: position, plane, mask and emit-count state plus the per-byte step logic.
// Depends on pbd_pkg. Produces at most one run per accepted body byte.
`timescale 1ns / 1ps

module pbd_core import pbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_start,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_push,
    output t_result    o_res
);

    t_phase              r_phase,     n_phase;
    logic [7:0]          r_lit_left,  n_lit_left;
    logic [ROWB_W-1:0]   r_row_pos,   n_row_pos;
    logic [PLANE_W-1:0]  r_plane,     n_plane;
    logic                r_mask_row,  n_mask_row;
    logic [EMIT_W-1:0]   r_emitted,   n_emitted;
    logic [ROWS_W-1:0]   r_rows_done, n_rows_done;
    logic                r_finished,  n_finished;
    logic                n_push;
    t_result             n_res;

    // One step of the decoder for the byte on the input.
    always_comb begin
        logic [7:0]         ecnt;
        logic [7:0]         cnt;
        logic               emit;
        logic [TOTAL_W-1:0] left;
        n_phase     = r_phase;
        n_lit_left  = r_lit_left;
        n_row_pos   = r_row_pos;
        n_plane     = r_plane;
        n_mask_row  = r_mask_row;
        n_emitted   = r_emitted;
        n_rows_done = r_rows_done;
        n_finished  = r_finished;
        emit        = 1'b0;
        ecnt        = 8'd0;

        // Start of a body clears everything before this byte is used.
        if (i_start) begin
            n_phase     = PH_CTRL;
            n_lit_left  = 8'd0;
            n_row_pos   = '0;
            n_plane     = '0;
            n_mask_row  = 1'b0;
            n_emitted   = '0;
            n_rows_done = '0;
            n_finished  = 1'b0;
        end

        if (n_finished || ({{(TOTAL_W-EMIT_W){1'b0}}, n_emitted} >= i_cfg.total)) begin
            n_finished = 1'b1;
        end else if (i_cfg.compressed) begin
            unique case (n_phase)
                PH_LIT: begin
                    n_lit_left = n_lit_left - 8'd1;
                    if (n_lit_left == 8'd0) begin
                        n_phase = PH_CTRL;
                    end
                    emit = !n_mask_row;
                    ecnt = 8'd1;
                end
                PH_REP: begin
                    n_phase = PH_CTRL;
                    emit    = !n_mask_row;
                    ecnt    = n_lit_left;
                end
                default: begin
                    // Control byte; a finished plane row rolls over first.
                    n_phase = PH_CTRL;
                    if (n_row_pos >= i_cfg.rb) begin
                        n_plane = n_plane + 4'd1;
                        if ((n_plane == i_cfg.np && !i_cfg.has_mask) ||
                            ({1'b0, n_plane} == {1'b0, i_cfg.np} + 5'd1 && i_cfg.has_mask)) begin
                            n_mask_row  = 1'b0;
                            n_plane     = '0;
                            n_rows_done = n_rows_done + 13'd1;
                        end
                        if (i_cfg.has_mask && n_plane == i_cfg.np) begin
                            n_mask_row = 1'b1;
                        end
                        n_row_pos = '0;
                    end
                    if (i_byte < NOOP_CTRL) begin
                        n_lit_left = i_byte + 8'd1;
                        n_phase    = PH_LIT;
                        n_row_pos  = n_row_pos + {5'd0, i_byte} + 13'd1;
                    end else if (i_byte > NOOP_CTRL) begin
                        n_lit_left = 8'(9'd257 - {1'b0, i_byte});
                        n_phase    = PH_REP;
                        n_row_pos  = n_row_pos + 13'(9'd257 - {1'b0, i_byte});
                    end
                end
            endcase
        end else begin
            unique case (n_phase)
                PH_LIT: begin
                    // Mask row: consumed without output.
                    n_row_pos = n_row_pos + 13'd1;
                    if (n_row_pos >= i_cfg.rb) begin
                        n_row_pos = '0;
                        if (i_cfg.pad_odd) begin
                            n_phase = PH_REP;
                        end else begin
                            n_phase     = PH_CTRL;
                            n_rows_done = n_rows_done + 13'd1;
                        end
                    end
                end
                PH_REP: begin
                    // Pad byte closes the row.
                    n_phase     = PH_CTRL;
                    n_rows_done = n_rows_done + 13'd1;
                end
                default: begin
                    n_phase   = PH_CTRL;
                    n_row_pos = n_row_pos + 13'd1;
                    if (n_row_pos >= i_cfg.rb) begin
                        n_row_pos = '0;
                        n_plane   = n_plane + 4'd1;
                        if (n_plane >= i_cfg.np) begin
                            n_plane = '0;
                            if (i_cfg.has_mask) begin
                                n_phase = PH_LIT;
                            end else if (i_cfg.pad_odd) begin
                                n_phase = PH_REP;
                            end else begin
                                n_rows_done = n_rows_done + 13'd1;
                            end
                        end
                    end
                    emit = 1'b1;
                    ecnt = 8'd1;
                end
            endcase
        end

        // Clip the run to what is left of the image and count it.
        left = i_cfg.total - {{(TOTAL_W-EMIT_W){1'b0}}, n_emitted};
        cnt  = ecnt;
        if ({{(TOTAL_W-8){1'b0}}, ecnt} > left) begin
            cnt = left[7:0];
        end
        if (emit) begin
            n_emitted = n_emitted + {{(EMIT_W-8){1'b0}}, cnt};
        end
        n_res.out_byte  = i_byte;
        n_res.out_count = cnt;
        n_res.body_done = 1'b0;
        if (emit && ({{(TOTAL_W-EMIT_W){1'b0}}, n_emitted} >= i_cfg.total)) begin
            n_finished      = 1'b1;
            n_res.body_done = 1'b1;
        end
        n_push = i_accept && emit;
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CTRL;
            r_lit_left  <= 8'd0;
            r_row_pos   <= '0;
            r_plane     <= '0;
            r_mask_row  <= 1'b0;
            r_emitted   <= '0;
            r_rows_done <= '0;
            r_finished  <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_row_pos   <= n_row_pos;
            r_plane     <= n_plane;
            r_mask_row  <= n_mask_row;
            r_emitted   <= n_emitted;
            r_rows_done <= n_rows_done;
            r_finished  <= n_finished;
        end
    end

    assign o_push = n_push;
    assign o_res  = n_res;

endmodule

@@ design/pbd_skid.sv @@
// Two-entry output buffer: an output register backed by a skid register.
// Depends on pbd_pkg for the run type.
`timescale 1ns / 1ps

module pbd_skid import pbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_v && i_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    // Payload moves: skid drains first, then a new run.
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_room  = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

@@ design/packbits_planar_body_decoder.sv @@
// ByteRun1 (PackBits) body decoder: takes one body byte per beat and gives decoded
// runs as value/count pairs, dropping mask rows and pad bytes and ending the image once
// rows*planes*row_bytes bytes are out. A byte is taken every cycle while the output
// buffer has room and no input hold is pending; each byte's work is one pass from the
// state registers into the two-entry output buffer. After reset and after every
// configuration write the input holds off while the image size product is recomputed
// in two registered multiply steps. Depends on pbd_pkg, pbd_core and pbd_skid.
`timescale 1ns / 1ps

module packbits_planar_body_decoder import pbd_pkg::*; #(
    parameter int MAX_ROW_BYTES = 4096,
    parameter int MAX_ROWS      = 4096,
    parameter int MAX_PLANES    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Body bytes in.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,    // [7:0] in_byte
    input  logic                  i_s_tuser,    // start_body
    // Runs out.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,    // [7:0] out_byte, [15:8] out_count
    output logic                  o_m_tlast,    // body_done
    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_compressed;
    logic [ROWB_W-1:0]    r_row_bytes;
    logic [PLANE_W-1:0]   r_planes;
    logic                 r_has_mask;
    logic [ROWS_W-1:0]    r_rows;
    logic                 r_pad_odd;
    logic [1:0]           r_hold;
    logic [PROD_W-1:0]    r_rb_np;
    logic [TOTAL_W-1:0]   r_total;
    logic [ROWB_W-1:0]    rb;
    logic [PLANE_W-1:0]   np;
    logic [ROWS_W-1:0]    nr;
    logic                 cfg_wr;
    logic                 accept;
    logic                 room;
    logic                 push;
    t_cfg                 core_cfg;
    t_result              core_res;
    t_result              out_res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed <= 1'b1;
            r_row_bytes  <= 13'd320;
            r_planes     <= 4'd1;
            r_has_mask   <= 1'b0;
            r_rows       <= 13'd200;
            r_pad_odd    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_COMPRESSED: r_compressed <= i_cfg_data[0];
                CFG_ROW_BYTES:  r_row_bytes  <= i_cfg_data[ROWB_W-1:0];
                CFG_PLANES:     r_planes     <= i_cfg_data[PLANE_W-1:0];
                CFG_HAS_MASK:   r_has_mask   <= i_cfg_data[0];
                CFG_ROWS:       r_rows       <= i_cfg_data[ROWS_W-1:0];
                CFG_PAD_ODD:    r_pad_odd    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturate the size settings at their limits.
    always_comb begin
        rb = r_row_bytes;
        np = r_planes;
        nr = r_rows;
        if ({{(32-ROWB_W){1'b0}}, r_row_bytes} > 32'(MAX_ROW_BYTES)) begin
            rb = ROWB_W'(MAX_ROW_BYTES);
        end
        if ({{(32-PLANE_W){1'b0}}, r_planes} > 32'(MAX_PLANES)) begin
            np = PLANE_W'(MAX_PLANES);
        end
        if ({{(32-ROWS_W){1'b0}}, r_rows} > 32'(MAX_ROWS)) begin
            nr = ROWS_W'(MAX_ROWS);
        end
    end

    // Image size in two registered multiply steps.
    always_ff @(posedge i_clk) begin
        r_rb_np <= {{PLANE_W{1'b0}}, rb} * {{ROWB_W{1'b0}}, np};
        r_total <= {{ROWS_W{1'b0}}, r_rb_np} * {{PROD_W{1'b0}}, nr};
    end

    // Input hold while the size product settles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 2'd2;
        end else if (cfg_wr) begin
            r_hold <= 2'd2;
        end else if (r_hold != 2'd0) begin
            r_hold <= r_hold - 2'd1;
        end
    end

    assign o_s_tready = room && (r_hold == 2'd0);
    assign accept     = i_s_tvalid && o_s_tready;

    assign core_cfg.compressed = r_compressed;
    assign core_cfg.has_mask   = r_has_mask;
    assign core_cfg.pad_odd    = r_pad_odd;
    assign core_cfg.rb         = rb;
    assign core_cfg.np         = np;
    assign core_cfg.total      = r_total;

    pbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_start  (i_s_tuser),
        .i_byte   (i_s_tdata),
        .i_cfg    (core_cfg),
        .o_push   (push),
        .o_res    (core_res)
    );

    pbd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (core_res),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.out_count, out_res.out_byte};
    assign o_m_tlast = out_res.body_done;

endmodule
